// File: design/c_tok_pkg.sv
// Shared types, constants and the keyword table for the C token classifier.
`default_nettype none
package c_tok_pkg;
   localparam int MAX_LINE = 512;
   localparam int KEYWORD_CHARS = 8;
   localparam int KEYWORD_COUNT = 14;
   localparam int POS_W = 9;
   localparam int LEN_W = 10;
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE - 1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LINE);

   typedef enum logic [3:0] {
      CLS_IDENT   = 4'd0,
      CLS_KEYWORD = 4'd1,
      CLS_OCTAL   = 4'd2,
      CLS_HEX     = 4'd3,
      CLS_DECIMAL = 4'd4,
      CLS_BAD     = 4'd5,
      CLS_OPER    = 4'd6,
      CLS_SEPAR   = 4'd7,
      CLS_STRING  = 4'd8,
      CLS_CHAR    = 4'd9
   } tok_class_type;

   typedef struct packed {
      tok_class_type    token_class;
      logic [POS_W-1:0] start_offset;
      logic [LEN_W-1:0] token_length;
      logic [3:0]       keyword_index;
      logic [7:0]       first_char;
      logic [7:0]       second_char;
      logic             last_of_run;
   } tok_rec_type;

   typedef struct packed {
      logic [1:0]  count;
      tok_rec_type rec0;
      tok_rec_type rec1;
   } tok_push_type;

   // keyword text, first character in the lowest byte, zero padded
   function automatic logic [63:0] kw_text(input logic [3:0] k);
      logic [63:0] s;
      logic [63:0] r;
      case (k)
         4'd0:    s = 64'("int");
         4'd1:    s = 64'("char");
         4'd2:    s = 64'("void");
         4'd3:    s = 64'("if");
         4'd4:    s = 64'("else");
         4'd5:    s = 64'("switch");
         4'd6:    s = 64'("case");
         4'd7:    s = 64'("default");
         4'd8:    s = 64'("while");
         4'd9:    s = 64'("do");
         4'd10:   s = 64'("for");
         4'd11:   s = 64'("break");
         4'd12:   s = 64'("continue");
         4'd13:   s = 64'("return");
         default: s = '1;
      endcase
      // literal is right aligned with the first character highest: reorder
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (s[8*i +: 8] != 8'd0) begin
            r = (r << 8) | 64'(s[8*i +: 8]);
         end
      end
      if (k > 4'd13) begin
         r = '1;
      end
      return r;
   endfunction
endpackage
`default_nettype wire

// File: design/c_tok_lexer.sv
// Lexer state and per-byte classification; yields up to two token records.
`default_nettype none
module c_tok_lexer
   import c_tok_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire logic [7:0]   source_byte,
   input  wire logic         end_of_line,
   output tok_push_type      push
);
   typedef enum logic [1:0] {MODE_IDLE, MODE_WORD, MODE_STR, MODE_CHR} mode_type;

   mode_type         mode_ff, mode_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [63:0]      prefix_ff, prefix_in;
   logic [2:0]       flags_ff, flags_in;
   logic [7:0]       held_ff, held_in;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction
   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
   endfunction
   function automatic logic is_oper(input logic [7:0] c);
      return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "!" ||
             c == "&" || c == "|" || c == "=" || c == ">" || c == "<";
   endfunction
   function automatic logic starts_pair(input logic [7:0] c);
      return c == "&" || c == "+" || c == "-" || c == "|" || c == ">" || c == "<" ||
             c == "=" || c == "!";
   endfunction
   function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
      logic r;
      if (a == "&" || a == "+" || a == "-" || a == "|") begin
         r = (b == a);
      end else if (a == ">" || a == "<" || a == "=" || a == "!") begin
         r = (b == "=");
      end else begin
         r = 1'b0;
      end
      return r;
   endfunction
   function automatic logic is_separ(input logic [7:0] c);
      return c == "," || c == ":" || c == ";" || c == "(" || c == ")" || c == "{" ||
             c == "}";
   endfunction

   function automatic tok_rec_type make_rec(input tok_class_type cls,
                                            input logic [POS_W-1:0] st,
                                            input logic [LEN_W-1:0] len,
                                            input logic [3:0] kw,
                                            input logic [7:0] fc,
                                            input logic [7:0] sc);
      tok_rec_type r;
      r.token_class = cls;
      r.start_offset = st;
      r.token_length = len;
      r.keyword_index = kw;
      r.first_char = fc;
      r.second_char = sc;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   function automatic tok_rec_type flush_rec(input logic [63:0] pfx,
                                             input logic [LEN_W-1:0] cnt,
                                             input logic [2:0] flg,
                                             input logic [POS_W-1:0] st);
      logic [7:0]    d;
      logic [7:0]    s;
      tok_class_type cls;
      logic [3:0]    kw;
      logic          hit;
      d = pfx[7:0];
      s = (cnt > LEN_W'(1)) ? pfx[15:8] : 8'd0;
      kw = 4'd0;
      hit = 1'b0;
      if (is_digit(d)) begin
         if (d == "0" && cnt > LEN_W'(1) && s != "x") begin
            cls = flg[0] ? CLS_OCTAL : CLS_BAD;
         end else if (d == "0" && s == "x") begin
            cls = flg[1] ? CLS_HEX : CLS_BAD;
         end else begin
            cls = flg[2] ? CLS_DECIMAL : CLS_BAD;
         end
      end else begin
         cls = CLS_IDENT;
         if (cnt <= LEN_W'(KEYWORD_CHARS)) begin
            for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
               if (pfx == kw_text(4'(k))) begin
                  hit = 1'b1;
                  kw = 4'(k);
               end
            end
         end
         if (hit) begin
            cls = CLS_KEYWORD;
         end
      end
      return make_rec(cls, st, cnt, kw, d, 8'd0);
   endfunction

   tok_rec_type rec_a, rec_b, rec_c;
   logic        va, vb, vc;
   logic [7:0]  quote;
   logic        consumed;
   logic [LEN_W-1:0] cnt_inc;

   always_comb begin
      mode_in = mode_ff;
      start_in = start_ff;
      count_in = count_ff;
      prefix_in = prefix_ff;
      flags_in = flags_ff;
      held_in = held_ff;
      pos_in = pos_ff;
      va = 1'b0;
      vb = 1'b0;
      vc = 1'b0;
      rec_a = '0;
      rec_b = '0;
      rec_c = '0;
      consumed = 1'b0;
      cnt_inc = (count_ff < LEN_MAX) ? count_ff + LEN_W'(1) : count_ff;
      quote = (mode_ff == MODE_STR) ? 8'h22 : 8'd39;

      if (mode_ff == MODE_STR || mode_ff == MODE_CHR) begin
         count_in = cnt_inc;
         if (source_byte == quote) begin
            vc = 1'b1;
            rec_c = make_rec((mode_ff == MODE_STR) ? CLS_STRING : CLS_CHAR,
                             start_ff, cnt_inc, 4'd0, quote, 8'd0);
            mode_in = MODE_IDLE;
         end
      end else begin
         if (held_ff != 8'd0) begin
            va = 1'b1;
            if (is_pair(held_ff, source_byte)) begin
               rec_a = make_rec(CLS_OPER, start_ff, LEN_W'(2), 4'd0, held_ff, source_byte);
               consumed = 1'b1;
            end else begin
               rec_a = make_rec(CLS_OPER, start_ff, LEN_W'(1), 4'd0, held_ff, 8'd0);
            end
            held_in = 8'd0;
         end
         if (!consumed) begin
            if (is_letter(source_byte) || is_digit(source_byte)) begin
               if (mode_ff != MODE_WORD) begin
                  mode_in = MODE_WORD;
                  start_in = pos_ff;
                  count_in = LEN_W'(1);
                  prefix_in = 64'(source_byte);
                  flags_in = 3'b111;
               end else begin
                  if (!(source_byte >= "0" && source_byte <= "7")) flags_in[0] = 1'b0;
                  if (!is_digit(source_byte)) flags_in[2] = 1'b0;
                  if (count_ff >= LEN_W'(2) && !is_hex(source_byte)) flags_in[1] = 1'b0;
                  if (count_ff < LEN_W'(KEYWORD_CHARS)) begin
                     prefix_in[8*count_ff[2:0] +: 8] = source_byte;
                  end
                  count_in = cnt_inc;
               end
               if (end_of_line) begin
                  vb = 1'b1;
                  rec_b = flush_rec(prefix_in, count_in, flags_in, start_in);
               end
            end else begin
               if (mode_ff == MODE_WORD) begin
                  vb = 1'b1;
                  rec_b = flush_rec(prefix_ff, count_ff, flags_ff, start_ff);
                  mode_in = MODE_IDLE;
               end
               if (is_oper(source_byte)) begin
                  if (starts_pair(source_byte) && !end_of_line) begin
                     held_in = source_byte;
                     start_in = pos_ff;
                  end else begin
                     vc = 1'b1;
                     rec_c = make_rec(CLS_OPER, pos_ff, LEN_W'(1), 4'd0, source_byte, 8'd0);
                  end
               end else if (is_separ(source_byte)) begin
                  vc = 1'b1;
                  rec_c = make_rec(CLS_SEPAR, pos_ff, LEN_W'(1), 4'd0, source_byte, 8'd0);
               end else if ((source_byte == 8'h22 || source_byte == 8'd39) &&
                            !end_of_line) begin
                  mode_in = (source_byte == 8'h22) ? MODE_STR : MODE_CHR;
                  start_in = pos_ff;
                  count_in = LEN_W'(1);
               end
            end
         end
      end

      if (end_of_line) begin
         mode_in = MODE_IDLE;
         pos_in = '0;
         start_in = '0;
         count_in = '0;
         prefix_in = '0;
         flags_in = '0;
         held_in = '0;
      end else if (pos_ff < POS_MAX) begin
         pos_in = pos_ff + POS_W'(1);
      end

      // pack records in emission order: held operator, word, single byte
      push.count = 2'(va) + 2'(vb) + 2'(vc);
      push.rec0 = va ? rec_a : (vb ? rec_b : rec_c);
      push.rec1 = va ? (vb ? rec_b : rec_c) : rec_c;
      push.rec0.last_of_run = (push.count == 2'd1);
      push.rec1.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pos_ff <= '0;
         start_ff <= '0;
         count_ff <= '0;
         prefix_ff <= '0;
         flags_ff <= '0;
         held_ff <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         start_ff <= start_in;
         count_ff <= count_in;
         prefix_ff <= prefix_in;
         flags_ff <= flags_in;
         held_ff <= held_in;
      end
   end
endmodule
`default_nettype wire

// File: design/c_tok_outq.sv
// Four-word result queue, takes up to two records per cycle.
`default_nettype none
module c_tok_outq
   import c_tok_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push_en,
   input  wire tok_push_type push,
   output logic        room,
   output logic        out_valid,
   input  wire logic   out_ready,
   output tok_rec_type out_rec
);
   tok_rec_type entry_ff [4];
   logic [1:0]  rd_ff, rd_in;
   logic [1:0]  wr_ff, wr_in;
   logic [2:0]  fill_ff, fill_in;
   logic [1:0]  n_push;
   logic        pop;

   assign room = (fill_ff <= 3'd2);
   assign out_valid = (fill_ff != 3'd0);
   assign out_rec = entry_ff[rd_ff];
   assign pop = out_valid && out_ready;
   assign n_push = push_en ? push.count : 2'd0;

   always_comb begin
      rd_in = rd_ff + 2'(pop);
      wr_in = wr_ff + n_push;
      fill_in = fill_ff + 3'(n_push) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         entry_ff[wr_ff] <= push.rec0;
      end
      if (n_push == 2'd2) begin
         entry_ff[wr_ff + 2'd1] <= push.rec1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         fill_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         fill_ff <= fill_in;
      end
   end
endmodule
`default_nettype wire

// File: design/c_token_classifier.sv
// C token classifier: one source byte per word in, token records out.
//
// req channel: one source byte per word, req_tlast on the last byte of a line.
// rsp channel: one token record per word; rsp_tlast marks the last record
// caused by one input byte (a byte causes zero, one or two records).
// The lexer is combinational; an accepted byte's records are written into
// the result queue at the accepting edge. Throughput is one byte per cycle
// while req_tready is high; req_tready drops only while the four-word
// result queue has fewer than two free slots, the room a byte with two records needs.
// An operator byte that may pair is held until the next byte decides it;
// a line end flushes it. Unterminated literals are dropped at line end.
// Reset empties the queue and returns the lexer to the start of a line.
// A stalled receiver fills the queue, after which bytes are refused.
`default_nettype none
module c_token_classifier
   import c_tok_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] source_byte
   input  wire logic        req_tlast,   // end_of_line
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [8:0] start_offset, [18:9] token_length,
                                         // [22:19] keyword_index, [30:23] first_char,
                                         // [38:31] second_char, [39] zero
   output logic [3:0]       rsp_tuser,   // [3:0] token_class
   output logic             rsp_tlast    // last_of_run
);
   tok_push_type push;
   tok_rec_type  out_rec;
   logic         step;

   assign step = req_tvalid && req_tready;

   c_tok_lexer u_lexer (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .source_byte (req_tdata),
      .end_of_line (req_tlast),
      .push        (push)
   );

   c_tok_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push_en   (step),
      .push      (push),
      .room      (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (out_rec)
   );

   assign rsp_tdata = {1'b0, out_rec.second_char, out_rec.first_char,
                       out_rec.keyword_index, out_rec.token_length,
                       out_rec.start_offset};
   assign rsp_tuser = out_rec.token_class;
   assign rsp_tlast = out_rec.last_of_run;
endmodule
`default_nettype wire

// File: bench/token_checker.sv
// Token record predictor and checker for the C token classifier bench.
module token_checker
   import c_tok_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,
   input  wire logic [3:0]  rsp_tuser,
   input  wire logic        rsp_tlast,
   output int               fail_count,
   output int               pending_tokens,
   output int               token_total,
   output int               class_seen
);
   typedef enum logic [1:0] {LX_IDLE, LX_WORD, LX_STR, LX_CHR} lex_mode_type;

   lex_mode_type    lx_mode;
   logic [9:0]      lx_pos;
   logic [8:0]      lx_start;
   logic [9:0]      lx_count;
   logic [63:0]     lx_prefix;
   logic [2:0]      lx_flags;  // [0] octal ok, [1] hex ok, [2] decimal ok
   logic [7:0]      lx_held;
   tok_rec_type     expected_tokens[$];
   tok_rec_type     step_out[$];

   assign pending_tokens = expected_tokens.size();

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction
   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic bit is_hex(logic [7:0] c);
      return is_digit(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
   endfunction
   function automatic bit is_oper(logic [7:0] c);
      return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "!" ||
             c == "&" || c == "|" || c == "=" || c == ">" || c == "<";
   endfunction
   function automatic bit is_separ(logic [7:0] c);
      return c == "," || c == ":" || c == ";" || c == "(" || c == ")" ||
             c == "{" || c == "}";
   endfunction
   function automatic bit pairs_with(logic [7:0] a, logic [7:0] b);
      if (a == "&" || a == "+" || a == "-" || a == "|") return b == a;
      if (a == ">" || a == "<" || a == "=" || a == "!") return b == "=";
      return 0;
   endfunction
   function automatic logic [63:0] keyword_text(int k);
      string w;
      logic [63:0] r;
      case (k)
         0: w = "int";      1: w = "char";    2: w = "void";   3: w = "if";
         4: w = "else";     5: w = "switch";  6: w = "case";   7: w = "default";
         8: w = "while";    9: w = "do";      10: w = "for";   11: w = "break";
         12: w = "continue"; default: w = "return";
      endcase
      r = '0;
      for (int i = 0; i < w.len(); i++) r[8*i +: 8] = w[i];
      return r;
   endfunction

   task automatic push_token(tok_class_type cls, logic [9:0] start, int len,
                             logic [3:0] kw, logic [7:0] fc, logic [7:0] sc);
      tok_rec_type r;
      r.token_class   = cls;
      r.start_offset  = (start > POS_MAX) ? POS_MAX : start[8:0];
      r.token_length  = (len > MAX_LINE) ? LEN_MAX : LEN_W'(len);
      r.keyword_index = kw;
      r.first_char    = fc;
      r.second_char   = sc;
      r.last_of_run   = 0;
      step_out.push_back(r);
   endtask

   task automatic flush_word();
      logic [7:0] d, s;
      tok_class_type cls;
      logic [3:0] kw;
      d = lx_prefix[7:0];
      s = (lx_count > 1) ? lx_prefix[15:8] : 8'd0;
      kw = 0;
      if (is_digit(d)) begin
         if (d == "0" && lx_count > 1 && s != "x") cls = lx_flags[0] ? CLS_OCTAL : CLS_BAD;
         else if (d == "0" && s == "x") cls = lx_flags[1] ? CLS_HEX : CLS_BAD;
         else cls = lx_flags[2] ? CLS_DECIMAL : CLS_BAD;
      end else begin
         cls = CLS_IDENT;
         if (lx_count <= KEYWORD_CHARS)
            for (int k = KEYWORD_COUNT - 1; k >= 0; k--)
               if (lx_prefix == keyword_text(k)) begin
                  cls = CLS_KEYWORD;
                  kw = 4'(k);
               end
      end
      push_token(cls, {1'b0, lx_start}, lx_count, kw, d, 0);
      lx_mode = LX_IDLE;
   endtask

   task automatic lex_byte(logic [7:0] c, bit eol);
      bit consumed;
      logic [9:0] pos;
      pos = lx_pos;
      consumed = 0;
      step_out.delete();
      if (lx_mode == LX_STR || lx_mode == LX_CHR) begin
         logic [7:0] q;
         q = (lx_mode == LX_STR) ? 8'd34 : 8'd39;
         if (lx_count < MAX_LINE) lx_count++;
         if (c == q) begin
            push_token(lx_mode == LX_STR ? CLS_STRING : CLS_CHAR, {1'b0, lx_start},
                       lx_count, 0, q, 0);
            lx_mode = LX_IDLE;
         end
      end else begin
         if (lx_held != 0) begin
            if (pairs_with(lx_held, c)) begin
               push_token(CLS_OPER, {1'b0, lx_start}, 2, 0, lx_held, c);
               consumed = 1;
            end else push_token(CLS_OPER, {1'b0, lx_start}, 1, 0, lx_held, 0);
            lx_held = 0;
         end
         if (!consumed) begin
            if (is_letter(c) || is_digit(c)) begin
               if (lx_mode != LX_WORD) begin
                  lx_mode = LX_WORD;
                  lx_start = pos[8:0];
                  lx_count = 1;
                  lx_prefix = {56'd0, c};
                  lx_flags = 3'b111;
               end else begin
                  if (!(c >= "0" && c <= "7")) lx_flags[0] = 0;
                  if (!is_digit(c)) lx_flags[2] = 0;
                  if (lx_count >= 2 && !is_hex(c)) lx_flags[1] = 0;
                  if (lx_count < KEYWORD_CHARS) lx_prefix[8*lx_count +: 8] = c;
                  if (lx_count < MAX_LINE) lx_count++;
               end
               if (eol) flush_word();
            end else begin
               if (lx_mode == LX_WORD) flush_word();
               if (is_oper(c)) begin
                  if (c != "*" && c != "/" && c != "%" && !eol) begin
                     lx_held = c;
                     lx_start = pos[8:0];
                  end else push_token(CLS_OPER, pos, 1, 0, c, 0);
               end else if (is_separ(c)) push_token(CLS_SEPAR, pos, 1, 0, c, 0);
               else if ((c == 8'd34 || c == 8'd39) && !eol) begin
                  lx_mode = (c == 8'd34) ? LX_STR : LX_CHR;
                  lx_start = pos[8:0];
                  lx_count = 1;
               end
            end
         end
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].last_of_run = 1;
      foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
      if (eol) begin
         lx_mode = LX_IDLE; lx_pos = 0; lx_start = 0; lx_count = 0;
         lx_prefix = 0; lx_flags = 0; lx_held = 0;
      end else if (lx_pos < MAX_LINE - 1) lx_pos++;
   endtask

   always @(posedge clock) begin
      tok_rec_type got, want;
      if (reset) begin
         lx_mode <= LX_IDLE; lx_pos <= 0; lx_start <= 0; lx_count <= 0;
         lx_prefix <= 0; lx_flags <= 0; lx_held <= 0;
         expected_tokens.delete();
         fail_count <= 0;
         token_total <= 0;
         class_seen <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.token_class   = tok_class_type'(rsp_tuser);
            got.start_offset  = rsp_tdata[8:0];
            got.token_length  = rsp_tdata[18:9];
            got.keyword_index = rsp_tdata[22:19];
            got.first_char    = rsp_tdata[30:23];
            got.second_char   = rsp_tdata[38:31];
            got.last_of_run   = rsp_tlast;
            token_total <= token_total + 1;
            class_seen <= class_seen | (1 << rsp_tuser);
            if (expected_tokens.size() == 0) begin
               if (fail_count < 10) $display("unexpected token record %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_tokens.pop_front();
               if (got !== want || rsp_tdata[39] !== 1'b0) begin
                  if (fail_count < 10)
                     $display("token mismatch: expected %p got %p", want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // predict after popping so a same-edge result never meets its own prediction
         if (req_tvalid && req_tready) lex_byte(req_tdata, req_tlast);
      end
   end
endmodule

// File: bench/testbench.sv
// Stimulus, clock, reset and verdict for the C token classifier bench.
module testbench;
   import c_tok_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic [7:0] req_tdata = 0;
   logic req_tlast = 0;
   logic rsp_tready = 0;
   logic req_tready, rsp_tvalid, rsp_tlast;
   logic [39:0] rsp_tdata;
   logic [3:0] rsp_tuser;
   int fail_count, pending_tokens, token_total, class_seen;
   int idle_cycles = 0;
   int bytes_sent = 0;
   bit long_hold = 0;
   logic [7:0] line_text[$];

   always #5 clock = ~clock;

   c_token_classifier dut (.*);
   token_checker checker_i (.*);

   // receiver: own stall pattern, plus one long hold-off
   always @(posedge clock) begin
      if (long_hold) rsp_tready <= 0;
      else rsp_tready <= ($urandom_range(0, 3) != 0) || (bytes_sent % 200 < 40);
   end

   initial begin
      int hold;
      wait (bytes_sent >= 300);
      @(posedge clock);
      long_hold = 1;
      for (hold = 0; hold < 60; hold++) @(posedge clock);
      long_hold = 0;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
         $display("c_token_classifier verification failed");
         $finish;
      end
   end

   task automatic send_line();
      int gap;
      for (int i = 0; i < line_text.size(); i++) begin
         if ($urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            req_tvalid <= 0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1;
         req_tdata  <= line_text[i];
         req_tlast  <= (i == line_text.size() - 1);
         do @(posedge clock); while (!req_tready);
         bytes_sent++;
      end
      req_tvalid <= 0;
      line_text.delete();
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) line_text.push_back(s[i]);
   endtask

   function automatic string random_piece();
      string pool[] = '{"int", "char", "void", "if", "else", "switch", "case", "default",
                        "while", "do", "for", "break", "continue", "return", "x1", "Ab",
                        "intx", "continues", "0", "017", "018", "0x", "0x1F", "0xG",
                        "123", "12a", "9", "&&", "++", "--", "||", ">=", "<=", "==",
                        "!=", "&", "+", "*", "/", "%", "!", "<", ">", "=", "|", "-",
                        ",", ";", "(", ")", "{", "}", ":", " ", " ", "_", "\"ab\"",
                        "'c'", "\"\"", "\"x", "'", "dO", "INT"};
      return pool[$urandom_range(0, pool.size() - 1)];
   endfunction

   initial begin
      int n;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed lines: keywords, numbers, operators, literals, edge bytes
      add_text("int char void if else switch case default while do for break");
      send_line();
      add_text("continue return continues 0 07 08 0x 0xfF 0xg 12 1a x9 Zz");
      send_line();
      add_text("a&&b++ --c||d>=e<=f==g!=h&i+j*k/l%m!n<o>p=q|r-s,;:(){}");
      send_line();
      add_text("\"str ing\" 'c' \"open");
      send_line();
      line_text.push_back(8'd0); line_text.push_back(8'd255);
      line_text.push_back(8'd128); line_text.push_back("_");
      line_text.push_back("+");
      send_line();
      add_text("a'"); send_line();
      add_text("<"); send_line();
      add_text("9"); send_line();
      // long line: positions and lengths saturate
      for (int i = 0; i < 520; i++) line_text.push_back("a");
      add_text(" 'x'"); send_line();
      while (bytes_sent < 1100) begin
         n = $urandom_range(1, 12);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) line_text.push_back(8'($urandom));
            else add_text(random_piece());
            if ($urandom_range(0, 2) == 0) add_text(" ");
         end
         send_line();
      end
      wait (pending_tokens == 0);
      repeat (20) @(posedge clock);
      $display("sent %0d bytes, checked %0d token records, class mask %h",
               bytes_sent, token_total, class_seen);
      if (fail_count == 0 && pending_tokens == 0)
         $display("c_token_classifier verification clean");
      else
         $display("c_token_classifier verification failed");
      $finish;
   end
endmodule
